// ===== rtl/fmp_pkg.sv =====
// shared constants for the fourier magnitude projection
`timescale 1ns / 1ps
package fmp_pkg;
	localparam int WORD_BITS_DEF = 32;
	// extra root bits kept below the integer magnitude
	localparam int GUARD_BITS = 16;
endpackage

// ===== rtl/fmp_sqrt_cell.sv =====
// one cell of the square root chain: settles one root bit per item
`timescale 1ns / 1ps
module fmp_sqrt_cell #(
	parameter int RB = 48,
	parameter int IDX = 0,
	parameter int SDW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              v_in,
	input  logic [2*RB-1:0]   rad_in,
	input  logic [RB+1:0]     rem_in,
	input  logic [RB-1:0]     root_in,
	input  logic [SDW-1:0]    side_in,
	output logic              v_q,
	output logic [2*RB-1:0]   rad_q,
	output logic [RB+1:0]     rem_q,
	output logic [RB-1:0]     root_q,
	output logic [SDW-1:0]    side_q
);
	logic [RB+3:0] cand;
	logic [RB+3:0] trial;
	logic          ge;
	logic [RB+3:0] diff;

	assign cand  = {rem_in, rad_in[2*IDX+1 -: 2]};
	assign trial = {2'b00, root_in, 2'b01};
	assign ge    = (cand >= trial);
	assign diff  = cand - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= rad_in;
		rem_q  <= ge ? diff[RB+1:0] : cand[RB+1:0];
		root_q <= {root_in[RB-2:0], ge};
		side_q <= side_in;
	end
endmodule

// ===== rtl/fmp_div_cell.sv =====
// one cell of the divider chain: one quotient bit for both components
`timescale 1ns / 1ps
module fmp_div_cell #(
	parameter int RB = 48,
	parameter int NB = 79,
	parameter int QB = 33,
	parameter int IDX = 0,
	parameter int SDW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            v_in,
	input  logic [RB-1:0]   d_in,
	input  logic [NB-1:0]   nre_in,
	input  logic [NB-1:0]   nim_in,
	input  logic [RB-1:0]   rre_in,
	input  logic [RB-1:0]   rim_in,
	input  logic [QB-1:0]   qre_in,
	input  logic [QB-1:0]   qim_in,
	input  logic [SDW-1:0]  side_in,
	output logic            v_q,
	output logic [RB-1:0]   d_q,
	output logic [NB-1:0]   nre_q,
	output logic [NB-1:0]   nim_q,
	output logic [RB-1:0]   rre_q,
	output logic [RB-1:0]   rim_q,
	output logic [QB-1:0]   qre_q,
	output logic [QB-1:0]   qim_q,
	output logic [SDW-1:0]  side_q
);
	logic [RB:0] cre;
	logic [RB:0] cim;
	logic [RB:0] dx;
	logic        gre;
	logic        gim;
	logic [RB:0] sre;
	logic [RB:0] sim;

	assign cre = {rre_in, nre_in[IDX]};
	assign cim = {rim_in, nim_in[IDX]};
	assign dx  = {1'b0, d_in};
	assign gre = (cre >= dx);
	assign gim = (cim >= dx);
	assign sre = gre ? cre - dx : cre;
	assign sim = gim ? cim - dx : cim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		d_q    <= d_in;
		nre_q  <= nre_in;
		nim_q  <= nim_in;
		rre_q  <= sre[RB-1:0];
		rim_q  <= sim[RB-1:0];
		qre_q  <= {qre_in[QB-2:0], gre};
		qim_q  <= {qim_in[QB-2:0], gim};
		side_q <= side_in;
	end
endmodule

// ===== rtl/fourier_magnitude_projection.sv =====
// top level: fourier magnitude projection pipeline
//
//   channel   signals                                          direction
//   command   start, busy, sample_re, sample_im,               in (busy out)
//             measured_amplitude, is_measured
//   result    done, result_re, result_im,                      out
//             was_zero_magnitude, saturated
//
// one item per cycle; busy is always low, an item is taken whenever start is high
// registers along the path: three front stages, one sqrt cell per root bit,
// one divider cell per quotient bit and the output register
// done pulses for one cycle with each result; the receiver cannot stall
// reset clears only the valid bits along the chain
`timescale 1ns / 1ps
module fourier_magnitude_projection #(
	parameter int WORD_BITS = fmp_pkg::WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [WORD_BITS-1:0] sample_re,
	input  logic signed [WORD_BITS-1:0] sample_im,
	input  logic [WORD_BITS-2:0]        measured_amplitude,
	input  logic                        is_measured,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] result_re,
	output logic signed [WORD_BITS-1:0] result_im,
	output logic                        was_zero_magnitude,
	output logic                        saturated
);
	import fmp_pkg::*;

	localparam int W    = WORD_BITS;
	localparam int G    = GUARD_BITS;
	localparam int AW   = W - 1;
	localparam int SW   = 2 * W;          // sum of squares
	localparam int RB   = W + G;          // root bits of the guarded magnitude
	localparam int NB   = W + AW + G;     // dividend bits
	localparam int QB   = W + 1;          // quotient bits
	localparam int SDW2 = 4 + AW + 2 * W; // side data through the divider
	localparam int SDW  = SDW2 + 2 * NB;  // side data through the root chain

	// never stalls
	assign busy = 1'b0;

	// stage 1: magnitudes and signs
	logic          v_s1;
	logic [W-1:0]  mre_s1, mim_s1, re_s1, im_s1;
	logic [AW-1:0] amp_s1;
	logic          flag_s1, nre_s1, nim_s1;

	// stage 2: products
	logic          v_s2;
	logic [SW-1:0] sqre_s2, sqim_s2;
	logic [W+AW-1:0] pre_s2, pim_s2;
	logic [W-1:0]  re_s2, im_s2;
	logic [AW-1:0] amp_s2;
	logic          flag_s2, nre_s2, nim_s2, zero_s2;

	// stage 3: sum of squares, dividends
	logic          v_s3;
	logic [SW-1:0] sum_s3;
	logic [NB-1:0] dre_s3, dim_s3;
	logic [W-1:0]  re_s3, im_s3;
	logic [AW-1:0] amp_s3;
	logic          flag_s3, nre_s3, nim_s3, zero_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		// two's complement magnitude, the most negative word maps to 2^(W-1)
		mre_s1  <= sample_re[W-1] ? W'(-sample_re) : sample_re;
		mim_s1  <= sample_im[W-1] ? W'(-sample_im) : sample_im;
		nre_s1  <= sample_re[W-1];
		nim_s1  <= sample_im[W-1];
		re_s1   <= sample_re;
		im_s1   <= sample_im;
		amp_s1  <= measured_amplitude;
		flag_s1 <= is_measured;

		sqre_s2 <= SW'(mre_s1) * SW'(mre_s1);
		sqim_s2 <= SW'(mim_s1) * SW'(mim_s1);
		pre_s2  <= (W + AW)'(mre_s1) * (W + AW)'(amp_s1);
		pim_s2  <= (W + AW)'(mim_s1) * (W + AW)'(amp_s1);
		zero_s2 <= (mre_s1 == '0) && (mim_s1 == '0);
		re_s2   <= re_s1;
		im_s2   <= im_s1;
		amp_s2  <= amp_s1;
		flag_s2 <= flag_s1;
		nre_s2  <= nre_s1;
		nim_s2  <= nim_s1;

		sum_s3  <= sqre_s2 + sqim_s2;
		dre_s3  <= {pre_s2, {G{1'b0}}};
		dim_s3  <= {pim_s2, {G{1'b0}}};
		zero_s3 <= zero_s2;
		re_s3   <= re_s2;
		im_s3   <= im_s2;
		amp_s3  <= amp_s2;
		flag_s3 <= flag_s2;
		nre_s3  <= nre_s2;
		nim_s3  <= nim_s2;
	end

	// root chain: floor(sqrt(sum * 2^(2G))), one bit per cell
	logic            sv   [RB+1];
	logic [2*RB-1:0] srad [RB+1];
	logic [RB+1:0]   srem [RB+1];
	logic [RB-1:0]   sroot[RB+1];
	logic [SDW-1:0]  sside[RB+1];

	assign sv[0]    = v_s3;
	assign srad[0]  = {sum_s3, {(2 * G){1'b0}}};
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign sside[0] = {flag_s3, zero_s3, nre_s3, nim_s3, amp_s3, re_s3, im_s3,
		dre_s3, dim_s3};

	for (genvar i = 0; i < RB; i++) begin : g_sqrt
		fmp_sqrt_cell #(
			.RB(RB),
			.IDX(RB - 1 - i),
			.SDW(SDW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.v_in(sv[i]),
			.rad_in(srad[i]),
			.rem_in(srem[i]),
			.root_in(sroot[i]),
			.side_in(sside[i]),
			.v_q(sv[i+1]),
			.rad_q(srad[i+1]),
			.rem_q(srem[i+1]),
			.root_q(sroot[i+1]),
			.side_q(sside[i+1])
		);
	end

	// divider chain: dividend / guarded magnitude, one quotient bit per cell
	logic            dv   [QB+1];
	logic [RB-1:0]   dd   [QB+1];
	logic [NB-1:0]   dnre [QB+1];
	logic [NB-1:0]   dnim [QB+1];
	logic [RB-1:0]   drre [QB+1];
	logic [RB-1:0]   drim [QB+1];
	logic [QB-1:0]   dqre [QB+1];
	logic [QB-1:0]   dqim [QB+1];
	logic [SDW2-1:0] dside[QB+1];

	logic [NB-1:0] sq_nre, sq_nim;
	assign sq_nre = sside[RB][2*NB-1:NB];
	assign sq_nim = sside[RB][NB-1:0];

	assign dv[0]    = sv[RB];
	assign dd[0]    = sroot[RB];
	assign dnre[0]  = sq_nre;
	assign dnim[0]  = sq_nim;
	// quotient fits in QB bits, so the top dividend bits start as the remainder
	assign drre[0]  = RB'(sq_nre[NB-1:QB]);
	assign drim[0]  = RB'(sq_nim[NB-1:QB]);
	assign dqre[0]  = '0;
	assign dqim[0]  = '0;
	assign dside[0] = sside[RB][SDW-1:2*NB];

	for (genvar j = 0; j < QB; j++) begin : g_div
		fmp_div_cell #(
			.RB(RB),
			.NB(NB),
			.QB(QB),
			.IDX(QB - 1 - j),
			.SDW(SDW2)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.v_in(dv[j]),
			.d_in(dd[j]),
			.nre_in(dnre[j]),
			.nim_in(dnim[j]),
			.rre_in(drre[j]),
			.rim_in(drim[j]),
			.qre_in(dqre[j]),
			.qim_in(dqim[j]),
			.side_in(dside[j]),
			.v_q(dv[j+1]),
			.d_q(dd[j+1]),
			.nre_q(dnre[j+1]),
			.nim_q(dnim[j+1]),
			.rre_q(drre[j+1]),
			.rim_q(drim[j+1]),
			.qre_q(dqre[j+1]),
			.qim_q(dqim[j+1]),
			.side_q(dside[j+1])
		);
	end

	// unpack side data at the end of the chain
	logic          f_flag, f_zero, f_nre, f_nim;
	logic [AW-1:0] f_amp;
	logic [W-1:0]  f_re, f_im;
	assign {f_flag, f_zero, f_nre, f_nim, f_amp, f_re, f_im} = dside[QB];

	// round to nearest, ties away: bump when twice the remainder reaches the divisor
	logic [QB:0] qre_r, qim_r;
	logic [QB:0] lim_re, lim_im;
	logic        sat_re, sat_im;
	logic [W-1:0] ore, oim;

	always_comb begin
		qre_r  = {1'b0, dqre[QB]} +
			(QB + 1)'({drre[QB], 1'b0} >= {1'b0, dd[QB]});
		qim_r  = {1'b0, dqim[QB]} +
			(QB + 1)'({drim[QB], 1'b0} >= {1'b0, dd[QB]});
		lim_re = (QB + 1)'({1'b0, {(W - 1){1'b1}}}) + (QB + 1)'(f_nre);
		lim_im = (QB + 1)'({1'b0, {(W - 1){1'b1}}}) + (QB + 1)'(f_nim);
		sat_re = (qre_r > lim_re);
		sat_im = (qim_r > lim_im);
		ore    = sat_re ? lim_re[W-1:0] : qre_r[W-1:0];
		oim    = sat_im ? lim_im[W-1:0] : qim_r[W-1:0];
		if (f_nre) begin
			ore = W'(-ore);
		end
		if (f_nim) begin
			oim = W'(-oim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (!f_flag) begin
			// unflagged pixel passes through
			result_re          <= f_re;
			result_im          <= f_im;
			was_zero_magnitude <= 1'b0;
			saturated          <= 1'b0;
		end else if (f_zero) begin
			// zero sample takes the amplitude on the real axis
			result_re          <= {1'b0, f_amp};
			result_im          <= '0;
			was_zero_magnitude <= 1'b1;
			saturated          <= 1'b0;
		end else begin
			result_re          <= ore;
			result_im          <= oim;
			was_zero_magnitude <= 1'b0;
			saturated          <= sat_re | sat_im;
		end
	end
endmodule

// ===== test/tb_fourier_magnitude_projection.sv =====
// testbench for the fourier magnitude projection pipeline
`timescale 1ns / 1ps
module tb_fourier_magnitude_projection;
	import fmp_pkg::*;

	localparam int WB = WORD_BITS_DEF;
	// three front stages, sqrt cells, divider cells, output register
	localparam int PIPE_DEPTH = 3 + (WB + GUARD_BITS) + (WB + 1) + 1;
	localparam int N_RANDOM = 1530;

	// one projected pixel as the block reports it
	typedef struct packed {
		logic [WB-1:0] re;
		logic [WB-1:0] im;
		logic          zero_mag;
		logic          sat;
	} pixel_out_t;

	// one stimulus row; check_fixed means the typed-in result is used
	typedef struct {
		logic [WB-1:0] re;
		logic [WB-1:0] im;
		logic [WB-2:0] amp;
		logic          flag;
		logic          check_fixed;
		pixel_out_t    fixed;
	} pixel_row_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [WB-1:0] sample_re;
	logic [WB-1:0] sample_im;
	logic [WB-2:0] measured_amplitude;
	logic          is_measured;
	logic          done;
	logic [WB-1:0] result_re;
	logic [WB-1:0] result_im;
	logic          was_zero_magnitude;
	logic          saturated;

	pixel_out_t projected_q[$];
	int         n_errors;
	int         n_results;
	int         n_flagged;
	int         n_zero;
	int         n_sat;
	bit         stim_done;

	fourier_magnitude_projection #(.WORD_BITS(WB)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample_re(sample_re),
		.sample_im(sample_im),
		.measured_amplitude(measured_amplitude),
		.is_measured(is_measured),
		.done(done),
		.result_re(result_re),
		.result_im(result_im),
		.was_zero_magnitude(was_zero_magnitude),
		.saturated(saturated)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// floor of the integer square root of a 128-bit value by bit trial
	function automatic logic [63:0] root_floor(logic [127:0] x);
		logic [63:0]  r;
		logic [63:0]  c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= x)
				r = c;
		end
		return r;
	endfunction

	// one component: |c| * amp * 2^guard / magg, round half away, clip to range
	function automatic logic [WB-1:0] scale_part(logic [WB-1:0] c, logic [WB-2:0] amp,
			logic [63:0] magg, inout logic sat);
		logic          neg;
		logic [WB-1:0] mag;
		logic [127:0]  num;
		logic [127:0]  q;
		logic [127:0]  r;
		logic [127:0]  limit;
		neg = c[WB-1];
		mag = neg ? -c : c;
		num = ({96'd0, mag} * {97'd0, amp}) << GUARD_BITS;
		q = num / {64'd0, magg};
		r = num % {64'd0, magg};
		if (r >= {64'd0, magg} - r)
			q = q + 1;
		limit = (128'd1 << (WB - 1)) - 1 + (neg ? 1 : 0);
		if (q > limit) begin
			q = limit;
			sat = 1'b1;
		end
		return neg ? -q[WB-1:0] : q[WB-1:0];
	endfunction

	// expected output of the projection for one pixel
	function automatic pixel_out_t project_pixel(logic [WB-1:0] re, logic [WB-1:0] im,
			logic [WB-2:0] amp, logic flag);
		pixel_out_t   p;
		logic [WB-1:0] rm;
		logic [WB-1:0] imm;
		logic [127:0] s;
		logic [63:0]  magg;
		logic         sat;
		p = '{re: re, im: im, zero_mag: 1'b0, sat: 1'b0};
		if (!flag)
			return p;
		if (re == '0 && im == '0) begin
			p.re = {1'b0, amp};
			p.im = '0;
			p.zero_mag = 1'b1;
			return p;
		end
		rm = re[WB-1] ? -re : re;
		imm = im[WB-1] ? -im : im;
		s = {96'd0, rm} * {96'd0, rm} + {96'd0, imm} * {96'd0, imm};
		magg = root_floor(s << (2 * GUARD_BITS));
		sat = 1'b0;
		p.re = scale_part(re, amp, magg, sat);
		p.im = scale_part(im, amp, magg, sat);
		p.sat = sat;
		return p;
	endfunction

	task automatic report_mismatch(string what, logic [WB-1:0] got, logic [WB-1:0] want);
		n_errors++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
	endtask

	// result monitor: every done is compared with the oldest expectation
	always @(posedge clk) begin
		pixel_out_t want;
		if (arst_n && done) begin
			n_results++;
			if (projected_q.size() == 0) begin
				n_errors++;
				$display("unexpected result at %0t", $realtime);
			end else begin
				want = projected_q.pop_front();
				if (result_re !== want.re)
					report_mismatch("result_re", result_re, want.re);
				if (result_im !== want.im)
					report_mismatch("result_im", result_im, want.im);
				if (was_zero_magnitude !== want.zero_mag)
					report_mismatch("was_zero_magnitude", was_zero_magnitude, want.zero_mag);
				if (saturated !== want.sat)
					report_mismatch("saturated", saturated, want.sat);
			end
		end
	end

	// hand one pixel to the block; holds start until taken, gaps are inserted by the caller
	task automatic send_pixel(pixel_row_t row);
		pixel_out_t want;
		want = project_pixel(row.re, row.im, row.amp, row.flag);
		// a typed-in row must also agree with the predictor, else the predictor is off
		if (row.check_fixed && want !== row.fixed) begin
			n_errors++;
			$display("predictor disagrees with fixed row %h %h", row.re, row.im);
			want = row.fixed;
		end
		start <= 1'b1;
		sample_re <= row.re;
		sample_im <= row.im;
		measured_amplitude <= row.amp;
		is_measured <= row.flag;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		projected_q.push_back(want);
		n_flagged += row.flag;
		n_zero += want.zero_mag;
		n_sat += want.sat;
		@(negedge clk);
	endtask

	task automatic idle_gap(int cycles);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	localparam logic [WB-1:0] MAXP = {1'b0, {(WB-1){1'b1}}};
	localparam logic [WB-1:0] MINN = {1'b1, {(WB-1){1'b0}}};
	localparam logic [WB-2:0] AMAX = '1;
	localparam logic [WB-1:0] ONE = 32'h0001_0000;

	// directed rows: zero sample, unflagged pass-through, extremes up to the clip limit
	pixel_row_t directed[] = '{
		'{'0, '0, 31'h0001_0000, 1'b1, 1'b1, '{ONE, '0, 1'b1, 1'b0}},
		'{'0, '0, AMAX, 1'b1, 1'b1, '{MAXP, '0, 1'b1, 1'b0}},
		'{'0, '0, '0, 1'b1, 1'b1, '{'0, '0, 1'b1, 1'b0}},
		'{MINN, MAXP, AMAX, 1'b0, 1'b1, '{MINN, MAXP, 1'b0, 1'b0}},
		'{32'h1234_5678, 32'hdead_beef, '0, 1'b0, 1'b1,
			'{32'h1234_5678, 32'hdead_beef, 1'b0, 1'b0}},
		'{ONE, '0, 31'h0002_0000, 1'b1, 1'b1, '{32'h0002_0000, '0, 1'b0, 1'b0}},
		'{'0, -ONE, 31'h0003_0000, 1'b1, 1'b1, '{'0, -32'h0003_0000, 1'b0, 1'b0}},
		'{1, '0, AMAX, 1'b1, 1'b1, '{MAXP, '0, 1'b0, 1'b0}},
		'{MINN, '0, AMAX, 1'b1, 1'b1, '{MINN + 1, '0, 1'b0, 1'b0}},
		'{MINN, MINN, AMAX, 1'b1, 1'b0, '{'0, '0, 1'b0, 1'b0}},
		'{MAXP, MAXP, AMAX, 1'b1, 1'b0, '{'0, '0, 1'b0, 1'b0}},
		'{MAXP, MINN, 31'h1, 1'b1, 1'b0, '{'0, '0, 1'b0, 1'b0}},
		'{32'h0003_0000, 32'hfffc_0000, 31'h000a_0000, 1'b1, 1'b0, '{'0, '0, 1'b0, 1'b0}},
		'{1, 1, AMAX, 1'b1, 1'b0, '{'0, '0, 1'b0, 1'b0}},
		'{-1, 1, 31'h5555_5555, 1'b1, 1'b0, '{'0, '0, 1'b0, 1'b0}},
		'{32'h5555_5555, 32'haaaa_aaaa, 31'h2aaa_aaaa, 1'b1, 1'b0,
			'{'0, '0, 1'b0, 1'b0}},
		'{32'haaaa_aaaa, 32'h5555_5555, 31'h5555_5555, 1'b1, 1'b0,
			'{'0, '0, 1'b0, 1'b0}},
		'{'0, 7, 31'h7, 1'b1, 1'b0, '{'0, '0, 1'b0, 1'b0}}
	};

	// random pixel: mixes magnitude classes so rounding and zero samples occur
	function automatic pixel_row_t random_pixel();
		pixel_row_t row;
		int sh;
		row.re = WB'($urandom);
		row.im = WB'($urandom);
		row.amp = (WB - 1)'($urandom);
		case ($urandom_range(0, 7))
			0: begin
				row.re = '0;
				row.im = '0;
			end
			1: begin
				sh = $urandom_range(1, WB - 1);
				row.re = $signed(row.re) >>> sh;
				row.im = $signed(row.im) >>> $urandom_range(1, WB - 1);
			end
			2: row.amp = row.amp >> $urandom_range(1, WB - 2);
			3: begin
				row.re = $signed(row.re) >>> (WB - 4);
				row.im = $urandom_range(0, 1) ? '0 : row.im;
			end
			default: ;
		endcase
		row.flag = $urandom_range(0, 5) != 0;
		row.check_fixed = 1'b0;
		row.fixed = '0;
		return row;
	endfunction

	initial begin
		int tail;
		n_errors = 0;
		n_results = 0;
		n_flagged = 0;
		n_zero = 0;
		n_sat = 0;
		stim_done = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		sample_re = '0;
		sample_im = '0;
		measured_amplitude = '0;
		is_measured = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			send_pixel(directed[i]);
			if ($urandom_range(0, 2) == 0)
				idle_gap($urandom_range(1, 18));
		end

		// random part; the last stretch streams back to back with no gaps
		for (int i = 0; i < N_RANDOM; i++) begin
			send_pixel(random_pixel());
			if (i < N_RANDOM - 200 && $urandom_range(0, 5) == 0)
				idle_gap($urandom_range(1, 18));
		end
		start <= 1'b0;

		tail = 0;
		while (projected_q.size() != 0 && tail < 4 * PIPE_DEPTH) begin
			@(posedge clk);
			tail++;
		end
		repeat (PIPE_DEPTH) @(posedge clk);
		if (projected_q.size() != 0) begin
			n_errors++;
			$display("%0d results never arrived", projected_q.size());
		end
		$display("%0d pixels checked: %0d flagged, %0d zero-sample, %0d clipped",
			n_results, n_flagged, n_zero, n_sat);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== fourier_magnitude_projection.f =====
rtl/fmp_pkg.sv
rtl/fmp_sqrt_cell.sv
rtl/fmp_div_cell.sv
rtl/fourier_magnitude_projection.sv
test/tb_fourier_magnitude_projection.sv
